// File: src/rpr_pkg.sv
package rpr_pkg;

    localparam int MAX_RES         = 4;
    localparam int DEF_NUM_RES     = 4;
    localparam int DEF_HORIZON     = 1024;
    localparam int CMD_W           = 2;
    localparam int TIME_W          = 10;
    localparam int DUR_W           = 8;
    localparam int UNIT_W          = 8;
    localparam int USAGE_W         = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [USAGE_W-1:0] USAGE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_DRAIN,
        ST_QREAD,
        ST_QCAP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_issue;
        logic q_cap;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk;
        logic qread;
        logic last;
    } dp_status_t;

endpackage

// File: src/rpr_ctrl.sv
module rpr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rpr_pkg::dp_status_t  status,
    output rpr_pkg::ctrl_cmd_t   ctl
);
    import rpr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (status.walk)
                begin
                    state_next = ST_WALK;
                end
                else if (status.qread)
                begin
                    state_next = ST_QREAD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_WALK:
            begin
                ctl.rd_issue = 1'b1;
                if (status.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_QREAD:
            begin
                ctl.rd_issue = 1'b1;
                state_next   = ST_QCAP;
            end
            ST_QCAP:
            begin
                ctl.q_cap  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/rpr_datapath.sv
module rpr_datapath #(
    parameter int NUM_RES = rpr_pkg::DEF_NUM_RES,
    parameter int HORIZON = rpr_pkg::DEF_HORIZON
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rpr_pkg::CMD_W-1:0]       cmd,
    input  logic [rpr_pkg::TIME_W-1:0]      start_slot,
    input  logic [rpr_pkg::DUR_W-1:0]       duration,
    input  logic [rpr_pkg::UNIT_W-1:0]      demand_0,
    input  logic [rpr_pkg::UNIT_W-1:0]      demand_1,
    input  logic [rpr_pkg::UNIT_W-1:0]      demand_2,
    input  logic [rpr_pkg::UNIT_W-1:0]      demand_3,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]   query_resource,
    input  logic                            cfg_wr_en,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpr_pkg::UNIT_W-1:0]      cfg_data,
    input  rpr_pkg::ctrl_cmd_t              ctl,
    output rpr_pkg::dp_status_t             status,
    output logic                            fits,
    output logic [rpr_pkg::USAGE_W-1:0]     used_units,
    output logic [rpr_pkg::UNIT_W-1:0]      available_units,
    output logic                            range_error
);
    import rpr_pkg::*;

    localparam int SLOT_W = $clog2(HORIZON);

    function automatic logic [UNIT_W-1:0] free_units(input logic [USAGE_W-1:0] used,
                                                     input logic [UNIT_W-1:0]  cap);
        logic [USAGE_W-1:0] cap_ext;
        cap_ext = USAGE_W'(cap);
        if (used >= cap_ext)
        begin
            return '0;
        end
        return UNIT_W'(cap_ext - used);
    endfunction

    logic [UNIT_W-1:0]  cap_reg [MAX_RES];
    logic [UNIT_W-1:0]  dem_reg [MAX_RES];
    logic [UNIT_W-1:0]  in_dem  [MAX_RES];
    logic [CMD_W-1:0]   cmd_reg;
    logic [CFG_IDX_W-1:0] qres_reg;
    logic [TIME_W-1:0]  slot_reg;
    logic [DUR_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]  wr_slot_reg;
    logic [SLOT_W-1:0]  clr_reg;
    logic               pv_reg;
    logic               walk_reg;
    logic               qread_reg;
    logic               fits_reg;
    logic               rerr_reg;
    logic [USAGE_W-1:0] used_reg;
    logic [UNIT_W-1:0]  avail_reg;
    logic               out_fits_reg;
    logic               out_rerr_reg;
    logic [USAGE_W-1:0] out_used_reg;
    logic [UNIT_W-1:0]  out_avail_reg;

    logic [USAGE_W-1:0] rdata     [MAX_RES];
    logic [USAGE_W:0]   sum_w     [MAX_RES];
    logic [USAGE_W-1:0] mem_wdata [MAX_RES];
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [SLOT_W-1:0]  rd_addr;
    logic               fit_fail;
    logic               proc_check;
    logic               proc_commit;

    logic [TIME_W:0]    end_sum;
    logic               past;
    logic               q_past;
    logic               is_cc;
    logic               is_q;
    logic               res_ok;

    assign in_dem[0] = demand_0;
    assign in_dem[1] = demand_1;
    assign in_dem[2] = demand_2;
    assign in_dem[3] = demand_3;

    assign end_sum = (TIME_W+1)'(start_slot) + (TIME_W+1)'(duration);
    assign past    = 32'(end_sum) > 32'(HORIZON);
    assign q_past  = 32'(start_slot) >= 32'(HORIZON);
    assign is_cc   = (cmd == CMD_CHECK) || (cmd == CMD_COMMIT);
    assign is_q    = (cmd == CMD_QUERY);
    assign res_ok  = 32'(query_resource) < 32'(NUM_RES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                cap_reg[i] <= '1;
            end
        end
        else if (cfg_wr_en)
        begin
            cap_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            pv_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            pv_reg <= ctl.rd_issue;
        end
    end

    assign proc_check  = pv_reg && (cmd_reg == CMD_CHECK);
    assign proc_commit = pv_reg && (cmd_reg == CMD_COMMIT);

    always_comb
    begin
        fit_fail = 1'b0;
        for (int r = 0; r < MAX_RES; r++)
        begin
            sum_w[r] = (USAGE_W+1)'(rdata[r]) + (USAGE_W+1)'(dem_reg[r]);
            mem_wdata[r] = ctl.clr_step ? '0 :
                           (sum_w[r][USAGE_W] ? USAGE_MAX : sum_w[r][USAGE_W-1:0]);
            if ((r < NUM_RES) && (dem_reg[r] != '0)
                && (free_units(rdata[r], cap_reg[r]) < dem_reg[r]))
            begin
                fit_fail = 1'b1;
            end
        end
    end

    assign mem_we    = ctl.clr_step || proc_commit;
    assign mem_waddr = ctl.clr_step ? clr_reg : wr_slot_reg;
    assign rd_addr   = SLOT_W'(slot_reg);

    for (genvar r = 0; r < MAX_RES; r++)
    begin : g_bank
        if (r < NUM_RES)
        begin : g_mem
            logic [USAGE_W-1:0] mem [HORIZON];
            logic [USAGE_W-1:0] bank_q_reg;

            always_ff @(posedge clk)
            begin
                if (mem_we)
                begin
                    mem[mem_waddr] <= mem_wdata[r];
                end
                if (ctl.rd_issue)
                begin
                    bank_q_reg <= mem[rd_addr];
                end
            end

            assign rdata[r] = bank_q_reg;
        end
        else
        begin : g_none
            assign rdata[r] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            qres_reg  <= query_resource;
            slot_reg  <= start_slot;
            cnt_reg   <= duration;
            for (int i = 0; i < MAX_RES; i++)
            begin
                dem_reg[i] <= in_dem[i];
            end
            walk_reg  <= is_cc && !past && (duration != '0);
            qread_reg <= is_q && res_ok && !q_past;
            fits_reg  <= (cmd == CMD_CHECK) && !past;
            rerr_reg  <= (is_cc && past) || (is_q && res_ok && q_past);
            used_reg  <= '0;
            avail_reg <= (is_q && res_ok && q_past) ? cap_reg[query_resource] : '0;
        end
        else
        begin
            if (ctl.rd_issue)
            begin
                slot_reg    <= slot_reg + 1'b1;
                cnt_reg     <= cnt_reg - 1'b1;
                wr_slot_reg <= rd_addr;
            end
            if (proc_check && fit_fail)
            begin
                fits_reg <= 1'b0;
            end
            if (ctl.q_cap)
            begin
                used_reg  <= rdata[qres_reg];
                avail_reg <= free_units(rdata[qres_reg], cap_reg[qres_reg]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_fits_reg  <= fits_reg;
            out_rerr_reg  <= rerr_reg;
            out_used_reg  <= used_reg;
            out_avail_reg <= avail_reg;
        end
    end

    assign status.clr_last = (clr_reg == SLOT_W'(HORIZON - 1));
    assign status.walk     = walk_reg;
    assign status.qread    = qread_reg;
    assign status.last     = (cnt_reg == DUR_W'(1));

    assign fits            = out_fits_reg;
    assign used_units      = out_used_reg;
    assign available_units = out_avail_reg;
    assign range_error     = out_rerr_reg;

endmodule

// File: src/resource_profile_reservation_core.sv
// Channel  Handshake              Payload
// -------  ---------------------  -------------------------------------------------
// input    in_valid / in_ready    cmd, start_slot, duration, demand_0..3, query_resource
// output   out_valid / out_ready  fits, used_units, available_units, range_error
// config   cfg_wr_en              cfg_index, cfg_data
//
// Check and commit walk the window one slot per cycle through all usage banks at once.
// Each bank has a single read port; out-of-range and unknown items skip the table read.
// After reset a clearing pass zeroes every slot of the table; no transfer is taken then.
// A new item is taken while the previous result waits; a stalled output holds the item
// at its final step until the result register frees.
module resource_profile_reservation_core #(
    parameter int NUM_RES = rpr_pkg::DEF_NUM_RES,
    parameter int HORIZON = rpr_pkg::DEF_HORIZON
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rpr_pkg::CMD_W-1:0]       cmd,
    input  logic [rpr_pkg::TIME_W-1:0]      start_slot,
    input  logic [rpr_pkg::DUR_W-1:0]       duration,
    input  logic [rpr_pkg::UNIT_W-1:0]      demand_0,
    input  logic [rpr_pkg::UNIT_W-1:0]      demand_1,
    input  logic [rpr_pkg::UNIT_W-1:0]      demand_2,
    input  logic [rpr_pkg::UNIT_W-1:0]      demand_3,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]   query_resource,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            fits,
    output logic [rpr_pkg::USAGE_W-1:0]     used_units,
    output logic [rpr_pkg::UNIT_W-1:0]      available_units,
    output logic                            range_error,
    input  logic                            cfg_wr_en,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpr_pkg::UNIT_W-1:0]      cfg_data
);
    import rpr_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t status;

    rpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctl       (ctl)
    );

    rpr_datapath #(
        .NUM_RES (NUM_RES),
        .HORIZON (HORIZON)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .start_slot      (start_slot),
        .duration        (duration),
        .demand_0        (demand_0),
        .demand_1        (demand_1),
        .demand_2        (demand_2),
        .demand_3        (demand_3),
        .query_resource  (query_resource),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .ctl             (ctl),
        .status          (status),
        .fits            (fits),
        .used_units      (used_units),
        .available_units (available_units),
        .range_error     (range_error)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import rpr_pkg::*;

    localparam int SLOTS       = DEF_HORIZON;
    localparam int RES_COUNT   = DEF_NUM_RES;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int PHASE_ITEMS = 200;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    localparam int CAP_RES0 = 0;
    localparam int CAP_RES1 = 1;
    localparam int CAP_RES2 = 2;
    localparam int CAP_RES3 = 3;

    typedef struct packed {
        bit [CMD_W-1:0]                   cmd;
        bit [TIME_W-1:0]                  start_slot;
        bit [DUR_W-1:0]                   duration;
        bit [MAX_RES-1:0][UNIT_W-1:0]     demand;
        bit [CFG_IDX_W-1:0]               query_resource;
    } item_t;

    typedef struct packed {
        logic                  fits;
        logic [USAGE_W-1:0]    used_units;
        logic [UNIT_W-1:0]     available_units;
        logic                  range_error;
    } result_t;

    class profile_tracker;
        bit [USAGE_W-1:0] usage [MAX_RES][SLOTS];
        bit [UNIT_W-1:0]  cap [MAX_RES];
        result_t          awaited [$];
        int               errors;

        function new();
            foreach (cap[i])
                cap[i] = '1;
            errors = 0;
        endfunction

        function bit [UNIT_W-1:0] headroom(int res, int slot);
            if (usage[res][slot] >= USAGE_W'(cap[res]))
                return '0;
            return cap[res] - usage[res][slot][UNIT_W-1:0];
        endfunction

        function void accept_item(item_t it);
            result_t want;
            int      stop;
            int      sum;
            int      r;
            int      t;
            want = '0;
            stop = int'(it.start_slot) + int'(it.duration);
            case (it.cmd)
                CMD_CHECK:
                begin
                    if (stop > SLOTS)
                        want.range_error = 1'b1;
                    else
                    begin
                        want.fits = 1'b1;
                        for (r = 0; r < RES_COUNT && r < MAX_RES; r++)
                        begin
                            if (it.demand[r] != '0)
                            begin
                                for (t = int'(it.start_slot); t < stop; t++)
                                    if (headroom(r, t) < it.demand[r])
                                        want.fits = 1'b0;
                            end
                        end
                    end
                end
                CMD_COMMIT:
                begin
                    if (stop > SLOTS)
                        want.range_error = 1'b1;
                    else
                    begin
                        for (r = 0; r < RES_COUNT && r < MAX_RES; r++)
                        begin
                            for (t = int'(it.start_slot); t < stop; t++)
                            begin
                                sum = int'(usage[r][t]) + int'(it.demand[r]);
                                usage[r][t] = (sum > int'(USAGE_MAX)) ? USAGE_MAX
                                                                      : sum[USAGE_W-1:0];
                            end
                        end
                    end
                end
                CMD_QUERY:
                begin
                    if (int'(it.query_resource) < RES_COUNT)
                    begin
                        if (int'(it.start_slot) >= SLOTS)
                        begin
                            want.range_error     = 1'b1;
                            want.available_units = cap[it.query_resource];
                        end
                        else
                        begin
                            want.used_units      = usage[it.query_resource][it.start_slot];
                            want.available_units = headroom(int'(it.query_resource),
                                                            int'(it.start_slot));
                        end
                    end
                end
                default:
                begin
                end
            endcase
            awaited.push_back(want);
        endfunction

        function void report(string field, logic [USAGE_W-1:0] want,
                             logic [USAGE_W-1:0] got);
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            errors++;
        endfunction

        function void compare_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with none awaited: expected none got %0d %0d %0d %0d",
                         $time, got.fits, got.used_units, got.available_units,
                         got.range_error);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.fits !== want.fits)
                report("fits", USAGE_W'(want.fits), USAGE_W'(got.fits));
            if (got.used_units !== want.used_units)
                report("used_units", want.used_units, got.used_units);
            if (got.available_units !== want.available_units)
                report("available_units", USAGE_W'(want.available_units),
                       USAGE_W'(got.available_units));
            if (got.range_error !== want.range_error)
                report("range_error", USAGE_W'(want.range_error), USAGE_W'(got.range_error));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd;
    logic [TIME_W-1:0]     start_slot;
    logic [DUR_W-1:0]      duration;
    logic [UNIT_W-1:0]     demand_0;
    logic [UNIT_W-1:0]     demand_1;
    logic [UNIT_W-1:0]     demand_2;
    logic [UNIT_W-1:0]     demand_3;
    logic [CFG_IDX_W-1:0]  query_resource;
    logic                  out_valid;
    logic                  out_ready;
    logic                  fits;
    logic [USAGE_W-1:0]    used_units;
    logic [UNIT_W-1:0]     available_units;
    logic                  range_error;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [UNIT_W-1:0]     cfg_data;

    profile_tracker tracker;
    int             burst_left;
    int             cycle_count = 0;

    resource_profile_reservation_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .start_slot      (start_slot),
        .duration        (duration),
        .demand_0        (demand_0),
        .demand_1        (demand_1),
        .demand_2        (demand_2),
        .demand_3        (demand_3),
        .query_resource  (query_resource),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fits            (fits),
        .used_units      (used_units),
        .available_units (available_units),
        .range_error     (range_error),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[resource_profile_reservation_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            tracker.compare_result(result_t'{fits, used_units, available_units,
                                             range_error});
    end

    initial
    begin : receiver
        bit [15:0] ready_mask;
        int        span;
        int        pos;
        ready_mask = '1;
        span       = 0;
        pos        = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                span = int'($urandom_range(200, 20));
                case ($urandom_range(3))
                    0:       ready_mask = '1;
                    1:       ready_mask = 16'($urandom);
                    2:       ready_mask = 16'h0001;
                    default: ready_mask = 16'($urandom | $urandom);
                endcase
                if (ready_mask == '0)
                    ready_mask = 16'h0001;
            end
            out_ready = ready_mask[pos[3:0]];
            pos++;
            span--;
        end
    end

    function automatic item_t build_item(logic [CMD_W-1:0] c, int t0, int dur,
                                         int d0, int d1, int d2, int d3, int q);
        item_t it;
        it.cmd            = c;
        it.start_slot     = TIME_W'(t0);
        it.duration       = DUR_W'(dur);
        it.demand[0]      = UNIT_W'(d0);
        it.demand[1]      = UNIT_W'(d1);
        it.demand[2]      = UNIT_W'(d2);
        it.demand[3]      = UNIT_W'(d3);
        it.query_resource = CFG_IDX_W'(q);
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    hr;
        int    r;
        it   = '0;
        pick = int'($urandom_range(99));
        if (pick < 38)
            it.cmd = CMD_CHECK;
        else if (pick < 72)
            it.cmd = CMD_COMMIT;
        else if (pick < 96)
            it.cmd = CMD_QUERY;
        else
            it.cmd = CMD_UNKNOWN;
        it.start_slot = ($urandom_range(1) == 0) ? TIME_W'($urandom_range(47))
                                                 : TIME_W'($urandom_range(SLOTS - 1));
        pick = int'($urandom_range(99));
        if (pick < 82)
            it.duration = DUR_W'($urandom_range(12));
        else if (pick < 95)
            it.duration = DUR_W'($urandom_range(64, 13));
        else
            it.duration = DUR_W'($urandom_range(255, 65));
        // push the window past the end of the horizon
        if ($urandom_range(19) == 0)
        begin
            it.duration   = DUR_W'($urandom_range(255, 2));
            it.start_slot = TIME_W'($urandom_range(SLOTS - 1, SLOTS - int'(it.duration) + 1));
        end
        for (r = 0; r < MAX_RES; r++)
        begin
            pick = int'($urandom_range(9));
            if (pick < 3)
                it.demand[r] = '0;
            else if (pick < 7)
                it.demand[r] = UNIT_W'($urandom_range(8, 1));
            else if (pick < 9 && it.cmd == CMD_CHECK)
            begin
                hr = int'(tracker.headroom(r, int'(it.start_slot)))
                     + int'($urandom_range(2)) - 1;
                it.demand[r] = (hr < 0) ? '0 : ((hr > 255) ? '1 : UNIT_W'(hr));
            end
            else
                it.demand[r] = UNIT_W'($urandom_range(255));
        end
        it.query_resource = CFG_IDX_W'($urandom_range(3));
        return it;
    endfunction

    task automatic push_item(input item_t it);
        in_valid       = 1'b1;
        cmd            = it.cmd;
        start_slot     = it.start_slot;
        duration       = it.duration;
        demand_0       = it.demand[0];
        demand_1       = it.demand[1];
        demand_2       = it.demand[2];
        demand_3       = it.demand[3];
        query_resource = it.query_resource;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.accept_item(it);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid = 1'b0;
            if ($urandom_range(9) >= 3)
                repeat ($urandom_range(20, 1)) @(negedge clk);
            burst_left = int'($urandom_range(40, 1));
        end
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (tracker.awaited.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_cap(input int idx, input bit [UNIT_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = CFG_IDX_W'(idx);
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        tracker.cap[idx] = val;
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        int r;
        int pick;
        tracker        = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = '0;
        start_slot     = '0;
        duration       = '0;
        demand_0       = '0;
        demand_1       = '0;
        demand_2       = '0;
        demand_3       = '0;
        query_resource = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        burst_left     = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_item(build_item(CMD_QUERY,  0,    0,   0,   0,   0,   0,   0));
        push_item(build_item(CMD_CHECK,  0,    0,   255, 255, 255, 255, 0));
        push_item(build_item(CMD_CHECK,  1023, 1,   255, 255, 255, 255, 0));
        push_item(build_item(CMD_CHECK,  1023, 2,   255, 255, 255, 255, 3));
        push_item(build_item(CMD_COMMIT, 1023, 2,   255, 255, 255, 255, 0));
        push_item(build_item(CMD_COMMIT, 768,  255, 255, 0,   1,   128, 0));
        push_item(build_item(CMD_CHECK,  768,  255, 1,   0,   0,   0,   0));
        push_item(build_item(CMD_CHECK,  768,  255, 0,   0,   0,   0,   0));
        push_item(build_item(CMD_CHECK,  768,  255, 0,   0,   254, 127, 0));
        push_item(build_item(CMD_CHECK,  768,  255, 0,   0,   255, 128, 0));
        push_item(build_item(CMD_COMMIT, 5,    0,   255, 255, 255, 255, 0));
        push_item(build_item(CMD_QUERY,  5,    0,   0,   0,   0,   0,   1));
        push_item(build_item(CMD_QUERY,  768,  0,   0,   0,   0,   0,   0));
        push_item(build_item(CMD_QUERY,  1022, 0,   0,   0,   0,   0,   3));
        push_item(build_item(CMD_UNKNOWN, 1023, 255, 255, 255, 255, 255, 3));
        push_item(build_item(CMD_COMMIT, 1000, 24,  255, 255, 255, 255, 0));
        push_item(build_item(CMD_CHECK,  1001, 23,  1,   1,   1,   1,   0));
        push_item(build_item(CMD_CHECK,  1000, 25,  1,   1,   1,   1,   0));
        push_item(build_item(CMD_QUERY,  1023, 0,   0,   0,   0,   0,   2));
        push_item(build_item(CMD_CHECK,  0,    255, 255, 255, 255, 255, 0));
        push_item(build_item(CMD_QUERY,  1023, 0,   0,   0,   0,   0,   1));

        // drive one slot into saturation on every resource
        for (n = 0; n < 260; n++)
            push_item(build_item(CMD_COMMIT, 900, 1, 255, 255, 255, 255, 0));
        for (r = 0; r < MAX_RES; r++)
            push_item(build_item(CMD_QUERY, 900, 0, 0, 0, 0, 0, r));
        push_item(build_item(CMD_CHECK, 900, 1, 1, 0, 0, 0, 0));

        for (phase = 0; phase < 6; phase++)
        begin
            settle();
            for (r = CAP_RES0; r <= CAP_RES3; r++)
            begin
                case (phase)
                    1:       write_cap(r, 8'd0);
                    2:       write_cap(r, 8'd255);
                    3:       write_cap(r, UNIT_W'($urandom_range(40, 1)));
                    4:
                    begin
                        pick = int'($urandom_range(2));
                        write_cap(r, (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255
                                                                      : 8'($urandom));
                    end
                    default: write_cap(r, UNIT_W'($urandom_range(255)));
                endcase
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off until the block has answered everything
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    settle();
                push_item(random_item());
            end
        end

        settle();
        repeat (20) @(negedge clk);
        if (tracker.errors == 0)
            $display("[resource_profile_reservation_core] OK");
        else
            $display("[resource_profile_reservation_core] ERROR");
        $finish;
    end

endmodule

// File: resource_profile_reservation_core.f
src/rpr_pkg.sv
src/rpr_ctrl.sv
src/rpr_datapath.sv
src/resource_profile_reservation_core.sv
verif/tb.sv
